// File: rtl/ttd_pkg.sv
package ttd_pkg;

  // Event kinds carried on the op field.
  typedef enum logic [1:0] {
    OP_SYNC  = 2'd0,
    OP_KEY   = 2'd1,
    OP_ABS   = 2'd2,
    OP_OTHER = 2'd3
  } op_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_SWAP_AXES       = 3'd0,
    REG_OFFSET_X        = 3'd1,
    REG_OFFSET_Y        = 3'd2,
    REG_SCALE_X         = 3'd3,
    REG_SCALE_Y         = 3'd4,
    REG_BOUNCE_MS       = 3'd5,
    REG_DOUBLE_CLICK_MS = 3'd6,
    REG_CALIBRATING     = 3'd7
  } cfg_index_t;

  localparam int CfgDataW = 24;

  // Key codes that drive the touched flag.
  localparam logic [9:0] KeyTouch = 10'd330;
  localparam logic [9:0] KeyLeft  = 10'd272;

  // Both coordinate distances must stay below this for a double click.
  localparam logic signed [16:0] NearLimit = 17'sd20;

  // Depth of both queues; also bounds the clicks in flight in the back end.
  localparam int FifoDepth = 8;
  localparam int FifoIdxW  = $clog2(FifoDepth);
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  // Reset values of the configuration registers.
  localparam logic [23:0] ScaleReset  = 24'd65536;
  localparam logic [15:0] BounceReset = 16'd300;
  localparam logic [15:0] DblReset    = 16'd500;

  // Live configuration, shared by the front and back ends.
  typedef struct packed {
    logic               swap_axes;
    logic signed [15:0] offset_x;
    logic signed [15:0] offset_y;
    logic [23:0]        scale_x;
    logic [23:0]        scale_y;
    logic [15:0]        bounce_ms;
    logic [15:0]        double_click_ms;
    logic               calibrating;
  } cfg_t;

  // One queue entry: a coordinate pair and a flag. In the middle queue the
  // pair is raw and the flag marks a click inside the double-click window;
  // in the result queue the pair is final and the flag is the double click.
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               flag;
  } entry_t;

endpackage

// File: rtl/touch_event_tap_detector_top.sv
// Touch tap detector: takes one touch event per clock while full is low and
// turns each debounced release into a click with scaled coordinates (raw
// while calibrating) and a double-click flag. The front end classifies an
// event in the cycle it is accepted and queues the click; the back end
// offsets, scales (one 17 by 24 multiply per axis), saturates and compares
// against the previous click in a three-stage pipeline (s1, s2, s3) that
// feeds the result queue. Both sides sustain one beat per cycle unless a
// queue backs up; full rises only when the eight-entry click queue backs up
// behind the result queue. Configuration writes are taken in any cycle
// (cfg_ready is always high) and must only be issued while the block is idle.
module touch_event_tap_detector_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         op,
  input  logic [9:0]         event_code,
  input  logic signed [15:0] event_value,
  input  logic [31:0]        time_ms,
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] click_x,
  output logic signed [15:0] click_y,
  output logic               double_click
);

  ttd_pkg::cfg_t                 cfg;
  logic                          accept;
  logic                          click_push;
  ttd_pkg::entry_t               click_data;
  logic                          req_pop;
  logic                          req_empty;
  logic                          req_full;
  ttd_pkg::entry_t               req_data;
  logic [ttd_pkg::FifoCntW-1:0]  req_count;
  logic                          res_push;
  ttd_pkg::entry_t               res_data;
  logic                          res_pop;
  logic                          res_full;
  ttd_pkg::entry_t               res_head;
  logic [ttd_pkg::FifoCntW-1:0]  res_count;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;
  assign full      = req_full;
  assign res_pop   = pop && !empty;

  assign click_x      = res_head.x;
  assign click_y      = res_head.y;
  assign double_click = res_head.flag;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.swap_axes       <= 1'b0;
      cfg.offset_x        <= '0;
      cfg.offset_y        <= '0;
      cfg.scale_x         <= ttd_pkg::ScaleReset;
      cfg.scale_y         <= ttd_pkg::ScaleReset;
      cfg.bounce_ms       <= ttd_pkg::BounceReset;
      cfg.double_click_ms <= ttd_pkg::DblReset;
      cfg.calibrating     <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (ttd_pkg::cfg_index_t'(cfg_index))
        ttd_pkg::REG_SWAP_AXES:       cfg.swap_axes       <= cfg_data[0];
        ttd_pkg::REG_OFFSET_X:        cfg.offset_x        <= cfg_data[15:0];
        ttd_pkg::REG_OFFSET_Y:        cfg.offset_y        <= cfg_data[15:0];
        ttd_pkg::REG_SCALE_X:         cfg.scale_x         <= cfg_data;
        ttd_pkg::REG_SCALE_Y:         cfg.scale_y         <= cfg_data;
        ttd_pkg::REG_BOUNCE_MS:       cfg.bounce_ms       <= cfg_data[15:0];
        ttd_pkg::REG_DOUBLE_CLICK_MS: cfg.double_click_ms <= cfg_data[15:0];
        ttd_pkg::REG_CALIBRATING:     cfg.calibrating     <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  ttd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .accept      (accept),
    .op          (op),
    .event_code  (event_code),
    .event_value (event_value),
    .time_ms     (time_ms),
    .click_push  (click_push),
    .click_data  (click_data)
  );

  ttd_fifo u_req_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (click_push),
    .wr_data  (click_data),
    .rd_en    (req_pop),
    .rd_data  (req_data),
    .count    (req_count),
    .is_full  (req_full),
    .is_empty (req_empty)
  );

  ttd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req_empty (req_empty),
    .req_data  (req_data),
    .req_pop   (req_pop),
    .res_count (res_count),
    .res_push  (res_push),
    .res_data  (res_data)
  );

  ttd_fifo u_res_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (res_push),
    .wr_data  (res_data),
    .rd_en    (res_pop),
    .rd_data  (res_head),
    .count    (res_count),
    .is_full  (res_full),
    .is_empty (empty)
  );

endmodule

// File: rtl/ttd_fifo.sv
module ttd_fifo (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  ttd_pkg::entry_t               wr_data,
  input  logic                          rd_en,
  output ttd_pkg::entry_t               rd_data,
  output logic [ttd_pkg::FifoCntW-1:0]  count,
  output logic                          is_full,
  output logic                          is_empty
);

  ttd_pkg::entry_t                 mem [ttd_pkg::FifoDepth];
  logic [ttd_pkg::FifoIdxW-1:0]    wr_ptr;
  logic [ttd_pkg::FifoIdxW-1:0]    rd_ptr;

  assign is_full  = (count == ttd_pkg::FifoCntW'(ttd_pkg::FifoDepth));
  assign is_empty = (count == '0);
  assign rd_data  = mem[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

// File: rtl/ttd_front.sv
module ttd_front (
  input  logic               clk,
  input  logic               rst,
  input  ttd_pkg::cfg_t      cfg,
  input  logic               accept,
  input  logic [1:0]         op,
  input  logic [9:0]         event_code,
  input  logic signed [15:0] event_value,
  input  logic [31:0]        time_ms,
  output logic               click_push,
  output ttd_pkg::entry_t    click_data
);

  logic signed [15:0] cur_x;
  logic signed [15:0] cur_y;
  logic               pressed;
  logic [31:0]        prev_click_time;
  logic               have_prev_click;

  ttd_pkg::op_t       op_kind;
  logic [31:0]        elapsed;
  logic               debounce_ok;
  logic               in_window;
  logic               to_y;
  logic               is_key;

  assign op_kind = ttd_pkg::op_t'(op);
  assign elapsed = time_ms - prev_click_time;
  assign to_y    = (event_code == '0) != cfg.swap_axes;
  assign is_key  = (event_code == ttd_pkg::KeyTouch) || (event_code == ttd_pkg::KeyLeft);

  // Release classification: debounce and double-click window on raw time.
  always_comb begin
    debounce_ok = !have_prev_click || (elapsed >= {16'd0, cfg.bounce_ms});
    in_window   = have_prev_click && (elapsed < {16'd0, cfg.double_click_ms});
    click_push  = accept && (op_kind == ttd_pkg::OP_SYNC) && !pressed && debounce_ok;
    click_data.x    = cur_x;
    click_data.y    = cur_y;
    click_data.flag = in_window;
  end

  // Touch state, updated by each accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x           <= '0;
      cur_y           <= '0;
      pressed         <= 1'b0;
      prev_click_time <= '0;
      have_prev_click <= 1'b0;
    end else if (accept) begin
      unique case (op_kind)
        ttd_pkg::OP_ABS: begin
          if (to_y) begin
            cur_y <= event_value;
          end else begin
            cur_x <= event_value;
          end
        end
        ttd_pkg::OP_KEY: begin
          if (is_key) begin
            pressed <= (event_value != '0);
          end
        end
        ttd_pkg::OP_SYNC: begin
          if (click_push) begin
            prev_click_time <= time_ms;
            have_prev_click <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: rtl/ttd_back.sv
module ttd_back (
  input  logic                          clk,
  input  logic                          rst,
  input  ttd_pkg::cfg_t                 cfg,
  input  logic                          req_empty,
  input  ttd_pkg::entry_t               req_data,
  output logic                          req_pop,
  input  logic [ttd_pkg::FifoCntW-1:0]  res_count,
  output logic                          res_push,
  output ttd_pkg::entry_t               res_data
);

  // Stage one: offset applied, split into sign and magnitude.
  typedef struct packed {
    logic               neg_x;
    logic [16:0]        mag_x;
    logic               neg_y;
    logic [16:0]        mag_y;
    logic signed [15:0] raw_x;
    logic signed [15:0] raw_y;
    logic               win;
  } mag_stage_t;

  // Stage two: Q8.16 products with the fraction dropped.
  typedef struct packed {
    logic               neg_x;
    logic [24:0]        prod_x;
    logic               neg_y;
    logic [24:0]        prod_y;
    logic signed [15:0] raw_x;
    logic signed [15:0] raw_y;
    logic               win;
  } prod_stage_t;

  mag_stage_t        s1;
  prod_stage_t       s2;
  ttd_pkg::entry_t   s3;
  logic              v1;
  logic              v2;
  logic              v3;
  logic signed [15:0] prev_click_x;
  logic signed [15:0] prev_click_y;

  logic signed [16:0] sum_x;
  logic signed [16:0] sum_y;
  logic [40:0]        full_x;
  logic [40:0]        full_y;
  logic [1:0]         in_flight;
  logic [ttd_pkg::FifoCntW:0] occupancy;
  logic signed [16:0] dx;
  logic signed [16:0] dy;
  logic               near;

  // Saturate a sign and truncated magnitude to a signed 16-bit value.
  function automatic logic signed [15:0] saturate(input logic neg, input logic [24:0] p);
    logic [24:0] negated;
    negated = 25'd0 - p;
    if (neg) begin
      saturate = (p > 25'd32768) ? 16'sh8000 : negated[15:0];
    end else begin
      saturate = (p > 25'd32767) ? 16'sh7fff : p[15:0];
    end
  endfunction

  // Issue a request only when the result queue can hold every click in flight.
  always_comb begin
    in_flight = 2'({1'b0, v1} + {1'b0, v2} + {1'b0, v3});
    occupancy = {1'b0, res_count} + (ttd_pkg::FifoCntW + 1)'(in_flight);
    req_pop   = !req_empty && (occupancy < (ttd_pkg::FifoCntW + 1)'(ttd_pkg::FifoDepth));
  end

  // Offset sums, wide enough for any pair of 16-bit operands, and full scale products.
  always_comb begin
    sum_x  = 17'(req_data.x) + 17'(cfg.offset_x);
    sum_y  = 17'(req_data.y) + 17'(cfg.offset_y);
    full_x = 41'(s1.mag_x) * 41'(cfg.scale_x);
    full_y = 41'(s1.mag_y) * 41'(cfg.scale_y);
  end

  // Double-click test against the previous emitted click.
  always_comb begin
    dx       = 17'(s3.x) - 17'(prev_click_x);
    dy       = 17'(s3.y) - 17'(prev_click_y);
    near     = (dx < ttd_pkg::NearLimit) && (dx > -ttd_pkg::NearLimit)
            && (dy < ttd_pkg::NearLimit) && (dy > -ttd_pkg::NearLimit);
    res_push = v3;
    res_data.x    = s3.x;
    res_data.y    = s3.y;
    res_data.flag = s3.flag && near;
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= req_pop;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Pipeline payload and the last emitted coordinates.
  always_ff @(posedge clk) begin
    s1.neg_x <= sum_x[16];
    s1.mag_x <= sum_x[16] ? 17'(17'd0 - sum_x) : sum_x;
    s1.neg_y <= sum_y[16];
    s1.mag_y <= sum_y[16] ? 17'(17'd0 - sum_y) : sum_y;
    s1.raw_x <= req_data.x;
    s1.raw_y <= req_data.y;
    s1.win   <= req_data.flag;

    s2.neg_x  <= s1.neg_x;
    s2.prod_x <= full_x[40:16];
    s2.neg_y  <= s1.neg_y;
    s2.prod_y <= full_y[40:16];
    s2.raw_x  <= s1.raw_x;
    s2.raw_y  <= s1.raw_y;
    s2.win    <= s1.win;

    s3.x    <= cfg.calibrating ? s2.raw_x : saturate(s2.neg_x, s2.prod_x);
    s3.y    <= cfg.calibrating ? s2.raw_y : saturate(s2.neg_y, s2.prod_y);
    s3.flag <= s2.win;

    if (v3) begin
      prev_click_x <= s3.x;
      prev_click_y <= s3.y;
    end
  end

endmodule

// File: tb/touch_event_tap_detector_top_tb.sv
`timescale 1ns / 100ps

module touch_event_tap_detector_top_tb;
  import ttd_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 16;
  localparam int PhaseCount  = 8;
  localparam int PhaseItems  = 185;

  // Tracks the detector's state and holds the clicks it still owes.
  class tap_scoreboard;
    cfg_t               regs;
    logic signed [15:0] raw_x, raw_y;
    bit                 touched;
    logic signed [15:0] last_x, last_y;
    logic [31:0]        last_time;
    bit                 have_last;
    entry_t             clicks_due[$];
    int                 mismatches, clicks_seen, doubles_seen, events_seen;

    function new();
      regs = '0;
      regs.scale_x = ScaleReset;
      regs.scale_y = ScaleReset;
      regs.bounce_ms = BounceReset;
      regs.double_click_ms = DblReset;
      raw_x = '0;
      raw_y = '0;
      touched = 1'b0;
      last_x = '0;
      last_y = '0;
      last_time = '0;
      have_last = 1'b0;
      mismatches = 0;
      clicks_seen = 0;
      doubles_seen = 0;
      events_seen = 0;
    endfunction

    function void write_reg(cfg_index_t idx, logic [23:0] data);
      case (idx)
        REG_SWAP_AXES:       regs.swap_axes = data[0];
        REG_OFFSET_X:        regs.offset_x = data[15:0];
        REG_OFFSET_Y:        regs.offset_y = data[15:0];
        REG_SCALE_X:         regs.scale_x = data;
        REG_SCALE_Y:         regs.scale_y = data;
        REG_BOUNCE_MS:       regs.bounce_ms = data[15:0];
        REG_DOUBLE_CLICK_MS: regs.double_click_ms = data[15:0];
        REG_CALIBRATING:     regs.calibrating = data[0];
        default: ;
      endcase
    endfunction

    // Offset, Q8.16 multiply on the magnitude, truncate, then saturate.
    function logic signed [15:0] scale_axis(logic signed [15:0] raw,
                                            logic signed [15:0] off,
                                            logic [23:0] scale);
      longint biased, mag, prod, res;
      biased = longint'(raw) + longint'(off);
      mag = (biased < 0) ? -biased : biased;
      prod = (mag * longint'(scale)) >> 16;
      if (biased < 0) res = (prod > 32768) ? -32768 : -prod;
      else res = (prod > 32767) ? 32767 : prod;
      return 16'(res);
    endfunction

    function bit is_near(logic signed [15:0] a, logic signed [15:0] b);
      int d;
      d = int'(a) - int'(b);
      if (d < 0) d = -d;
      return d < int'(NearLimit);
    endfunction

    // Updates the state for one accepted event and queues any click it makes.
    function void note_event(op_t kind, logic [9:0] code, logic signed [15:0] value,
                             logic [31:0] now);
      logic [31:0]        elapsed;
      logic signed [15:0] x, y;
      entry_t             e;
      events_seen++;
      case (kind)
        OP_ABS: begin
          if ((code == 10'd0) != regs.swap_axes) raw_y = value;
          else raw_x = value;
        end
        OP_KEY: begin
          if (code == KeyTouch || code == KeyLeft) touched = (value != 0);
        end
        OP_SYNC: begin
          if (touched) return;
          elapsed = now - last_time;
          if (have_last && elapsed < 32'(regs.bounce_ms)) return;
          if (regs.calibrating) begin
            x = raw_x;
            y = raw_y;
          end else begin
            x = scale_axis(raw_x, regs.offset_x, regs.scale_x);
            y = scale_axis(raw_y, regs.offset_y, regs.scale_y);
          end
          e.x = x;
          e.y = y;
          e.flag = have_last && elapsed < 32'(regs.double_click_ms)
                   && is_near(last_x, x) && is_near(last_y, y);
          clicks_due.push_back(e);
          last_x = x;
          last_y = y;
          last_time = now;
          have_last = 1'b1;
        end
        default: ;
      endcase
    endfunction

    // Compares one result beat with the oldest click owed.
    function void check_click(logic signed [15:0] x, logic signed [15:0] y, logic dbl);
      entry_t e;
      if (clicks_due.size() == 0) begin
        $error("unexpected click: x=%0d y=%0d double_click=%0b", x, y, dbl);
        mismatches++;
        return;
      end
      e = clicks_due.pop_front();
      if (x !== e.x) begin
        $error("click_x: expected %0d, got %0d", e.x, x);
        mismatches++;
      end
      if (y !== e.y) begin
        $error("click_y: expected %0d, got %0d", e.y, y);
        mismatches++;
      end
      if (dbl !== e.flag) begin
        $error("double_click: expected %0b, got %0b", e.flag, dbl);
        mismatches++;
      end
      clicks_seen++;
      if (e.flag) doubles_seen++;
    endfunction
  endclass

  logic               clk;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [23:0]        cfg_data = '0;
  logic               push = 1'b0;
  logic               full;
  logic [1:0]         op = '0;
  logic [9:0]         event_code = '0;
  logic signed [15:0] event_value = '0;
  logic [31:0]        time_ms = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic signed [15:0] click_x, click_y;
  logic               double_click;

  tap_scoreboard      sb;
  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;
  int                 hold_left = 0;
  int                 items_sent = 0;
  int                 cfg_writes = 0;
  int                 cycle_count = 0;
  int                 input_stalls = 0;
  logic [31:0]        now_ms = 32'd5000;
  logic signed [15:0] tap_x = '0, tap_y = '0;

  touch_event_tap_detector_top uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .push(push), .full(full), .op(op), .event_code(event_code),
    .event_value(event_value), .time_ms(time_ms),
    .empty(empty), .pop(pop), .click_x(click_x), .click_y(click_y),
    .double_click(double_click)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog and a count of cycles where the input side was held off.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (push && full) input_stalls <= input_stalls + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side: check each popped beat, stall at random or for a long hold-off.
  initial begin
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (pop && !empty) sb.check_click(click_x, click_y, double_click);
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else begin
        pop <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Offers one event beat and returns at the edge where it is accepted.
  task send_event(op_t kind, logic [9:0] code, logic signed [15:0] value,
                  logic [31:0] stamp);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    op <= kind;
    event_code <= code;
    event_value <= value;
    time_ms <= stamp;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_event(kind, code, value, stamp);
    if (kind != OP_OTHER) items_sent++;
  endtask

  // Writes all eight registers back to back, junk in the unused upper bits.
  task write_regs(cfg_t c);
    cfg_index_t  idx;
    logic [23:0] data;
    for (int i = 0; i < 8; i++) begin
      idx = cfg_index_t'(i);
      data = 24'($urandom);
      case (idx)
        REG_SWAP_AXES:       data[0] = c.swap_axes;
        REG_OFFSET_X:        data[15:0] = c.offset_x;
        REG_OFFSET_Y:        data[15:0] = c.offset_y;
        REG_SCALE_X:         data = c.scale_x;
        REG_SCALE_Y:         data = c.scale_y;
        REG_BOUNCE_MS:       data[15:0] = c.bounce_ms;
        REG_DOUBLE_CLICK_MS: data[15:0] = c.double_click_ms;
        REG_CALIBRATING:     data[0] = c.calibrating;
        default: ;
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data <= data;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.write_reg(idx, data);
      cfg_writes++;
    end
    cfg_valid <= 1'b0;
  endtask

  // Waits for every owed click, then for the back-end pipeline to settle.
  task wait_idle();
    push <= 1'b0;
    while (sb.clicks_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Register settings per phase: reset values, two extreme sets, then random ones.
  function automatic cfg_t pick_plan(int p);
    cfg_t c;
    c = '0;
    case (p)
      0: begin
        c.scale_x = ScaleReset;
        c.scale_y = ScaleReset;
        c.bounce_ms = BounceReset;
        c.double_click_ms = DblReset;
      end
      1: begin
        c.swap_axes = 1'b1;
        c.offset_x = 16'sh8000;
        c.offset_y = 16'sh7FFF;
        c.scale_x = 24'hFFFFFF;
        c.scale_y = 24'd0;
        c.bounce_ms = 16'd0;
        c.double_click_ms = 16'hFFFF;
      end
      2: begin
        c.offset_x = 16'sh7FFF;
        c.offset_y = 16'sh8000;
        c.scale_x = ScaleReset;
        c.scale_y = ScaleReset;
        c.bounce_ms = 16'hFFFF;
        c.double_click_ms = 16'd0;
        c.calibrating = 1'b1;
      end
      default: begin
        c.swap_axes = 1'($urandom_range(0, 1));
        c.offset_x = $urandom_range(0, 1) ? 16'($urandom_range(0, 4000)) - 16'd2000
                                          : 16'($urandom);
        c.offset_y = $urandom_range(0, 1) ? 16'($urandom_range(0, 4000)) - 16'd2000
                                          : 16'($urandom);
        c.scale_x = ($urandom_range(0, 4) == 0) ? 24'($urandom)
                                                : 24'($urandom_range(16384, 262144));
        c.scale_y = ($urandom_range(0, 4) == 0) ? 24'($urandom)
                                                : 24'($urandom_range(16384, 262144));
        c.bounce_ms = 16'($urandom_range(0, 800));
        c.double_click_ms = 16'($urandom_range(0, 1500));
        c.calibrating = ($urandom_range(0, 3) == 0);
      end
    endcase
    return c;
  endfunction

  // Time step between taps: mostly around the debounce and double-click bounds.
  function automatic logic [31:0] next_gap(cfg_t c);
    int          r;
    logic [31:0] b, w;
    b = 32'(c.bounce_ms);
    w = 32'(c.double_click_ms);
    r = $urandom_range(0, 9);
    if (r < 3) return (b == 0) ? 32'($urandom_range(0, 5)) : 32'($urandom_range(0, b - 1));
    if (r < 7) return b + ((w > b) ? $urandom_range(0, w - b) : $urandom_range(0, 100));
    if (r < 9) return $urandom_range(0, 3 * (w + b) + 100);
    return $urandom;
  endfunction

  // One touch: position, press, maybe a sync while pressed, release, sync.
  task run_tap(cfg_t c);
    logic [9:0] xcode, ycode, key;
    xcode = c.swap_axes ? 10'd0 : ($urandom_range(0, 1) ? 10'd1 : 10'($urandom_range(1, 1023)));
    ycode = c.swap_axes ? ($urandom_range(0, 1) ? 10'd1 : 10'($urandom_range(1, 1023))) : 10'd0;
    if ($urandom_range(0, 1)) tap_x = tap_x + 16'($urandom_range(0, 30)) - 16'd15;
    else tap_x = 16'($urandom);
    if ($urandom_range(0, 1)) tap_y = tap_y + 16'($urandom_range(0, 30)) - 16'd15;
    else tap_y = 16'($urandom);
    if ($urandom_range(0, 4) != 0) send_event(OP_ABS, xcode, tap_x, now_ms);
    if ($urandom_range(0, 4) != 0) send_event(OP_ABS, ycode, tap_y, now_ms);
    key = $urandom_range(0, 1) ? KeyTouch : KeyLeft;
    send_event(OP_KEY, key, 16'($urandom_range(1, 65535)), now_ms);
    if ($urandom_range(0, 3) == 0) send_event(OP_SYNC, 10'($urandom), 16'($urandom), now_ms);
    now_ms = now_ms + next_gap(c);
    key = $urandom_range(0, 1) ? KeyTouch : KeyLeft;
    send_event(OP_KEY, key, 16'sd0, now_ms);
    send_event(OP_SYNC, 10'($urandom), 16'($urandom), now_ms);
  endtask

  initial begin
    cfg_t plan;
    int   target;
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed events under the reset settings.
    send_event(OP_OTHER, 10'h3FF, 16'shFFFF, 32'hFFFF_FFFF);
    send_event(OP_ABS, 10'd0, 16'sh7FFF, 32'd0);
    send_event(OP_ABS, 10'd3, 16'sh8000, 32'd0);
    send_event(OP_KEY, 10'd100, 16'sd1, 32'd0);
    // First click ever: no debounce, never a double click.
    send_event(OP_SYNC, 10'd0, 16'sd0, 32'd1000);
    send_event(OP_KEY, KeyTouch, 16'sd1, 32'd1100);
    send_event(OP_SYNC, 10'd0, 16'sd0, 32'd2000);
    send_event(OP_KEY, KeyLeft, 16'sd0, 32'd2000);
    // Too soon after the last click, then inside the double-click window.
    send_event(OP_SYNC, 10'd0, 16'sd0, 32'd1100);
    send_event(OP_SYNC, 10'd0, 16'sd0, 32'd1400);
    send_event(OP_ABS, 10'd1, 16'sd0, 32'd1400);
    send_event(OP_ABS, 10'd0, 16'sd0, 32'd1400);
    // Elapsed time wrapping through zero.
    send_event(OP_SYNC, 10'd0, 16'sd0, 32'hFFFF_FF00);
    send_event(OP_SYNC, 10'd0, 16'sd0, 32'h0000_0050);
    send_event(OP_KEY, KeyTouch, 16'sh8000, 32'h0000_0100);
    send_event(OP_SYNC, 10'd0, 16'sd0, 32'h0001_0000);
    send_event(OP_KEY, KeyTouch, 16'sd0, 32'h0001_0000);
    send_event(OP_OTHER, 10'd0, 16'sd0, 32'h0001_0000);
    send_event(OP_ABS, 10'h3FF, 16'sh5555, 32'h0001_0000);
    send_event(OP_ABS, 10'd0, 16'shAAAA, 32'h0001_0000);
    send_event(OP_SYNC, 10'h3FF, 16'sh7FFF, 32'h4000_0000);
    wait_idle();

    // Random phases, each with its own settings and idling pattern.
    for (int p = 0; p < PhaseCount; p++) begin
      plan = pick_plan(p);
      write_regs(plan);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      // Long result-side hold-off with no debounce so the queues fill up.
      if (p == 1) hold_left = 400;
      target = items_sent + PhaseItems;
      while (items_sent < target) begin
        if ($urandom_range(0, 99) < 85) begin
          run_tap(plan);
        end else begin
          send_event(op_t'($urandom_range(0, 3)), 10'($urandom), 16'($urandom),
                     $urandom_range(0, 1) ? now_ms : 32'($urandom));
        end
      end
      wait_idle();
    end

    $display("Ran %0d events in %0d setting phases, %0d register writes.",
             sb.events_seen, PhaseCount + 1, cfg_writes);
    $display("Checked %0d clicks, %0d double clicks, %0d input stall cycles.",
             sb.clicks_seen, sb.doubles_seen, input_stalls);
    if (sb.mismatches == 0 && sb.clicks_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
